### rtl/core/ehd_pkg.sv
// Shared types and constants for the element header deframer.
package ehd_pkg;

   // Width of the remaining-bytes counter of a payload.
   localparam int unsigned LEFT_W = 31;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_END    = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       at_end;
   } req_payload_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] grp_num;
      logic signed [15:0] elem_num;
      logic signed [31:0] value_len;
      logic [7:0]         data_byte;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [15:0] grp_num;
      logic signed [15:0] elem_num;
      logic signed [31:0] value_len;
   } header_fields_type;

endpackage

### rtl/core/element_header_deframer_unit.sv
// Top level of the element header deframer: byte stream in, headers and data bytes out.
//
//   channel | direction | handshake                   | payload
//   req     | in        | req_valid / req_stall       | ehd_pkg::req_payload_type
//   rsp     | out       | rsp_valid / rsp_stall       | ehd_pkg::rsp_payload_type
//   csr     | in        | csr_write_enable            | csr_write_data (byte order)
//
// One byte is taken per cycle while not stalled; its result, if any, appears in the result
// register on the following cycle. Header bytes before the last one give no result.
// The next byte is taken while the result register is empty or being transferred.
// Reset is synchronous; during reset no transfer is taken and byte order reverts
// to little-endian.
module element_header_deframer_unit #(
   parameter int unsigned ID_BYTES     = 2,
   parameter int unsigned LENGTH_BYTES = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ehd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ehd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data
);

   localparam int unsigned HDR_TOTAL = 2 * ID_BYTES + LENGTH_BYTES;
   localparam int unsigned CNT_W     = $clog2(HDR_TOTAL);
   localparam int unsigned IDX_W     = $clog2(HDR_TOTAL - 1);

   logic                              little_endian_ff;
   logic [HDR_TOTAL-2:0][7:0]         hdr_bytes_ff, hdr_bytes_in;
   logic [CNT_W-1:0]                  hdr_count_ff, hdr_count_in;
   logic                              in_payload_ff, in_payload_in;
   logic [ehd_pkg::LEFT_W-1:0]        bytes_left_ff, bytes_left_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ehd_pkg::rsp_payload_type          rsp_data_ff, rsp_data_in;

   logic                              req_xfer;
   logic [ehd_pkg::LEFT_W-1:0]        left_dec;
   ehd_pkg::header_fields_type        fields;

   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign req_xfer  = req_valid & ~req_stall;
   assign left_dec  = bytes_left_ff - ehd_pkg::LEFT_W'(1);

   ehd_header_unpack #(
      .ID_BYTES     (ID_BYTES),
      .LENGTH_BYTES (LENGTH_BYTES)
   ) u_unpack (
      .hdr_bytes     ({req_payload.in_byte, hdr_bytes_ff}),
      .little_endian (little_endian_ff),
      .fields        (fields)
   );

   always_comb begin
      hdr_bytes_in  = hdr_bytes_ff;
      hdr_count_in  = hdr_count_ff;
      in_payload_in = in_payload_ff;
      bytes_left_in = bytes_left_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      if (req_xfer) begin
         priority if (req_payload.at_end) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_data_in.kind = (!in_payload_ff && hdr_count_ff == '0) ?
                               ehd_pkg::KIND_END : ehd_pkg::KIND_ERROR;
            hdr_bytes_in  = '0;
            hdr_count_in  = '0;
            in_payload_in = 1'b0;
            bytes_left_in = '0;
         end else if (in_payload_ff) begin
            bytes_left_in = left_dec;
            in_payload_in = (left_dec != '0);
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_data_in.kind      = ehd_pkg::KIND_DATA;
            rsp_data_in.data_byte = req_payload.in_byte;
            rsp_data_in.last      = (left_dec == '0);
         end else if (hdr_count_ff != CNT_W'(HDR_TOTAL - 1)) begin
            hdr_bytes_in[hdr_count_ff[IDX_W-1:0]] = req_payload.in_byte;
            hdr_count_in = hdr_count_ff + CNT_W'(1);
         end else begin
            // Final header byte: the fields are complete.
            hdr_bytes_in = '0;
            hdr_count_in = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in.kind      = ehd_pkg::KIND_HEADER;
            rsp_data_in.grp_num   = fields.grp_num;
            rsp_data_in.elem_num  = fields.elem_num;
            rsp_data_in.value_len = fields.value_len;
            if (fields.value_len[31] || fields.value_len == '0) begin
               rsp_data_in.last = 1'b1;
            end else begin
               in_payload_in = 1'b1;
               bytes_left_in = fields.value_len[ehd_pkg::LEFT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b1;
         hdr_bytes_ff     <= '0;
         hdr_count_ff     <= '0;
         in_payload_ff    <= 1'b0;
         bytes_left_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            little_endian_ff <= csr_write_data;
         end
         hdr_bytes_ff  <= hdr_bytes_in;
         hdr_count_ff  <= hdr_count_in;
         in_payload_ff <= in_payload_in;
         bytes_left_ff <= bytes_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### rtl/core/ehd_header_unpack.sv
// Assembles and sign-extends the three header fields from the gathered header bytes.
module ehd_header_unpack #(
   parameter int unsigned ID_BYTES     = 2,
   parameter int unsigned LENGTH_BYTES = 4,
   localparam int unsigned HDR_TOTAL   = 2 * ID_BYTES + LENGTH_BYTES
) (
   input  logic [HDR_TOTAL-1:0][7:0] hdr_bytes,
   input  logic                      little_endian,
   output ehd_pkg::header_fields_type fields
);

   logic [8*ID_BYTES-1:0]     group_raw;
   logic [8*ID_BYTES-1:0]     element_raw;
   logic [8*LENGTH_BYTES-1:0] length_raw;

   always_comb begin
      group_raw   = '0;
      element_raw = '0;
      length_raw  = '0;
      for (int k = 0; k < ID_BYTES; k++) begin
         if (little_endian) begin
            group_raw[8*k +: 8]   = hdr_bytes[k];
            element_raw[8*k +: 8] = hdr_bytes[ID_BYTES + k];
         end else begin
            group_raw[8*(ID_BYTES-1-k) +: 8]   = hdr_bytes[k];
            element_raw[8*(ID_BYTES-1-k) +: 8] = hdr_bytes[ID_BYTES + k];
         end
      end
      for (int k = 0; k < LENGTH_BYTES; k++) begin
         if (little_endian) begin
            length_raw[8*k +: 8] = hdr_bytes[2*ID_BYTES + k];
         end else begin
            length_raw[8*(LENGTH_BYTES-1-k) +: 8] = hdr_bytes[2*ID_BYTES + k];
         end
      end
   end

   // Each field is sign-extended from its own width.
   assign fields.grp_num   = 16'(signed'(group_raw));
   assign fields.elem_num  = 16'(signed'(element_raw));
   assign fields.value_len = 32'(signed'(length_raw));

endmodule

### rtl/core/ehd_checker.sv
// Port-level checker for the element header deframer, bound to the top level.
module ehd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input ehd_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input ehd_pkg::rsp_payload_type rsp_payload
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("result changed while stalled");

   // An end mark always yields an end or error result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.at_end |=>
         rsp_valid && (rsp_payload.kind == ehd_pkg::KIND_END ||
                       rsp_payload.kind == ehd_pkg::KIND_ERROR))
      else $error("end mark did not produce an end or error result");

   // Only header results carry header fields, and end or error never completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind != ehd_pkg::KIND_HEADER |->
         rsp_payload.grp_num == '0 && rsp_payload.elem_num == '0 &&
         rsp_payload.value_len == '0 &&
         (rsp_payload.kind == ehd_pkg::KIND_DATA || !rsp_payload.last))
      else $error("non-header result carries header fields or a bad last flag");

endmodule

bind element_header_deframer_unit ehd_checker u_ehd_checker (.*);

### bench/element_header_deframer_checker.sv
// Checker for the element header deframer: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module element_header_deframer_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  ehd_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  ehd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   output int                       error_count,
   output int                       pending_count,
   output int                       checked_count
);

   localparam int ID_BYTES     = 2;
   localparam int LENGTH_BYTES = 4;
   localparam int HEADER_BYTES = 2 * ID_BYTES + LENGTH_BYTES;
   localparam int PRINT_LIMIT  = 30;

   // Model state, mirroring the block after each transfer.
   logic                              little_endian;
   logic [8*(HEADER_BYTES-1)-1:0]     hdr_bytes;
   logic [2:0]                        hdr_count;
   logic                              in_payload;
   logic [ehd_pkg::LEFT_W-1:0]        bytes_left;

   ehd_pkg::rsp_payload_type expected_results [$];

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Assembles count bytes from the header, starting at byte first, and sign-extends to 32 bits.
   function automatic logic [31:0] join_field(input logic [63:0] hdr, input int first,
                                              input int count, input logic le);
      logic [63:0] v;
      v = '0;
      for (int k = 0; k < count; k++) begin
         if (le)
            v |= 64'(hdr[8*(first+k) +: 8]) << (8*k);
         else
            v = (v << 8) | 64'(hdr[8*(first+k) +: 8]);
      end
      if (v[8*count-1])
         v |= ~((64'd1 << (8*count)) - 64'd1);
      return v[31:0];
   endfunction

   task automatic advance_deframer(input ehd_pkg::req_payload_type item);
      ehd_pkg::rsp_payload_type r;
      logic [63:0]     hdr;
      logic [31:0]     g;
      logic [31:0]     e;
      logic [31:0]     len;
      r = '0;
      if (item.at_end) begin
         r.kind = (!in_payload && hdr_count == 0) ? ehd_pkg::KIND_END : ehd_pkg::KIND_ERROR;
         hdr_bytes  = '0;
         hdr_count  = '0;
         in_payload = 1'b0;
         bytes_left = '0;
         expected_results.push_back(r);
      end else if (in_payload) begin
         bytes_left = bytes_left - 1'b1;
         r.kind      = ehd_pkg::KIND_DATA;
         r.data_byte = item.in_byte;
         r.last      = (bytes_left == 0);
         if (bytes_left == 0)
            in_payload = 1'b0;
         expected_results.push_back(r);
      end else if (hdr_count + 1 < HEADER_BYTES) begin
         hdr_bytes[8*hdr_count +: 8] = item.in_byte;
         hdr_count = hdr_count + 1'b1;
      end else begin
         hdr = 64'(hdr_bytes);
         hdr[8*(HEADER_BYTES-1) +: 8] = item.in_byte;
         g   = join_field(hdr, 0, ID_BYTES, little_endian);
         e   = join_field(hdr, ID_BYTES, ID_BYTES, little_endian);
         len = join_field(hdr, 2 * ID_BYTES, LENGTH_BYTES, little_endian);
         r.kind      = ehd_pkg::KIND_HEADER;
         r.grp_num   = g[15:0];
         r.elem_num  = e[15:0];
         r.value_len = len;
         hdr_bytes = '0;
         hdr_count = '0;
         // A zero or negative length leaves nothing to pass through.
         if (len[31] || len == 0) begin
            r.last = 1'b1;
         end else begin
            in_payload = 1'b1;
            bytes_left = len[ehd_pkg::LEFT_W-1:0];
         end
         expected_results.push_back(r);
      end
   endtask

   task automatic compare_result(input ehd_pkg::rsp_payload_type got);
      ehd_pkg::rsp_payload_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result kind %0d with no expectation waiting", got.kind));
      end else begin
         want = expected_results.pop_front();
         checked_count++;
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.grp_num !== want.grp_num)
            report_mismatch($sformatf("grp_num %h, expected %h", got.grp_num, want.grp_num));
         if (got.elem_num !== want.elem_num)
            report_mismatch($sformatf("elem_num %h, expected %h",
                                      got.elem_num, want.elem_num));
         if (got.value_len !== want.value_len)
            report_mismatch($sformatf("value_len %h, expected %h",
                                      got.value_len, want.value_len));
         if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, expected %h",
                                      got.data_byte, want.data_byte));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         little_endian = 1'b1;
         hdr_bytes     = '0;
         hdr_count     = '0;
         in_payload    = 1'b0;
         bytes_left    = '0;
         expected_results.delete();
      end else begin
         // A result leaving now belongs to an earlier transfer, so compare before predicting.
         if (rsp_valid && !rsp_stall)
            compare_result(rsp_payload);
         if (req_valid && !req_stall)
            advance_deframer(req_payload);
         // A byte order write takes effect from the next transfer on.
         if (csr_write_enable)
            little_endian = csr_write_data;
      end
      pending_count = expected_results.size();
   end

endmodule

### bench/testbench.sv
// Testbench top for the element header deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int PHASE_ITEMS = 180;
   localparam int HOLD_CYCLES = 80;
   localparam int IDLE_PCT    = 25;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   ehd_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   ehd_pkg::rsp_payload_type rsp_payload;
   logic                     csr_write_enable;
   logic                     csr_write_data;

   int error_count;
   int pending_count;
   int checked_count;
   int items_sent;
   int end_marks;
   int wait_cycles;

   logic idle_enable;
   logic hold_request;

   element_header_deframer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   element_header_deframer_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   always #4 clock = ~clock;

   initial begin
      #1ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: random stalls, or one long hold-off when it is requested.
   initial begin
      logic held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !held) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end
         rsp_stall = idle_enable && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic [7:0] value, input logic is_end);
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_payload.in_byte = value;
      req_payload.at_end  = is_end;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
      if (is_end)
         end_marks++;
   endtask

   task automatic write_byte_order(input logic le);
      csr_write_enable = 1'b1;
      csr_write_data   = le;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Lets the block run dry: every expected result out, plus any header byte still in flight.
   task automatic drain;
      req_valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Header bytes in stream order, byte k at bits 8k.
   function automatic logic [63:0] pack_header(input logic [15:0] g, input logic [15:0] e,
                                               input logic [31:0] len, input logic le);
      if (le)
         return {len, e, g};
      return {len[7:0], len[15:8], len[23:16], len[31:24], e[7:0], e[15:8], g[7:0], g[15:8]};
   endfunction

   // Sends a header and its payload; cut_at >= 0 ends the stream after that many bytes.
   task automatic send_element(input logic [15:0] g, input logic [15:0] e,
                               input logic [31:0] len, input logic le, input int cut_at);
      logic [63:0] hdr;
      longint      total;
      hdr   = pack_header(g, e, len, le);
      total = 64'sd8 + ((len[31] || len == 0) ? 64'sd0 : longint'(len));
      for (int k = 0; k < total && k != cut_at; k++) begin
         if (k < 8)
            send_item(hdr[8*k +: 8], 1'b0);
         else
            send_item(8'($urandom), 1'b0);
      end
      if (cut_at >= 0)
         send_item(8'($urandom), 1'b1);
   endtask

   task automatic send_random_element(input logic le);
      logic [31:0] len;
      int          pick;
      int          cut_at;
      pick   = $urandom_range(99);
      cut_at = -1;
      if (pick < 12)
         len = '0;
      else if (pick < 24)
         len = {1'b1, 31'($urandom)};
      else if (pick < 29) begin
         // Far too long to finish, so the stream is always cut inside the payload.
         len    = {1'b0, 31'($urandom)} | 32'h0100_0000;
         cut_at = $urandom_range(28, 8);
      end else
         len = $urandom_range(12, 1);
      if (cut_at < 0 && $urandom_range(99) < 8)
         cut_at = $urandom_range(8 + ((len[31] || len == 0) ? 0 : int'(len)) - 1, 0);
      send_element(16'($urandom), 16'($urandom), len, le, cut_at);
   endtask

   task automatic run_random_phase(input logic le, input int quota);
      int stop_at;
      int noise;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 8) begin
            // Garbage bytes, then an end mark so that the stream lines up again.
            noise = $urandom_range(10, 1);
            repeat (noise) send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b1);
         end else begin
            send_random_element(le);
            if ($urandom_range(99) < 5)
               send_item(8'($urandom), 1'b1);
         end
      end
   endtask

   initial begin
      logic le;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      idle_enable      = 1'b1;
      hold_request     = 1'b0;
      items_sent       = 0;
      end_marks        = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed part, least significant byte first.
      write_byte_order(1'b1);
      send_item(8'h00, 1'b1);
      send_element(16'h8000, 16'h7FFF, 32'h8000_0000, 1'b1, -1);
      send_element(16'hFFFF, 16'h0000, 32'h0000_0001, 1'b1, -1);
      send_element(16'h0102, 16'h0304, 32'h0000_0005, 1'b1, 2);
      drain();

      // Directed part, most significant byte first: longest length, cut off right after the header.
      write_byte_order(1'b0);
      send_element(16'h1234, 16'h8001, 32'h7FFF_FFFF, 1'b0, 8);
      drain();

      run_random_phase(1'b1 == 1'b0, PHASE_ITEMS);
      drain();

      write_byte_order(1'b1);
      idle_enable = 1'b0;
      run_random_phase(1'b1, PHASE_ITEMS);
      drain();
      idle_enable = 1'b1;

      write_byte_order(1'b0);
      hold_request = 1'b1;
      run_random_phase(1'b0, PHASE_ITEMS);
      drain();

      le = 1'($urandom_range(1));
      write_byte_order(le);
      run_random_phase(le, PHASE_ITEMS);
      req_valid = 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      if (pending_count != 0) begin
         $display("timeout: %0d results never arrived", pending_count);
         $display("DONE: errors detected");
      end else begin
         repeat (4) @(negedge clock);
         $display("Run covered %0d stream items, %0d of them end marks, in both byte orders.",
                  items_sent, end_marks);
         $display("%0d results compared, including a %0d-cycle receiver hold-off.",
                  checked_count, HOLD_CYCLES);
         if (error_count == 0)
            $display("DONE: 0 errors");
         else
            $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/ehd_pkg.sv
rtl/core/ehd_header_unpack.sv
rtl/core/element_header_deframer_unit.sv
rtl/core/ehd_checker.sv
bench/element_header_deframer_checker.sv
bench/testbench.sv
